>>> src/berf_pkg.sv
package berf_pkg;

  // Column capacity and derived widths
  localparam int unsigned MAX_ROWS = 4096;
  localparam int unsigned ROW_AW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CNT_W    = $clog2(MAX_ROWS + 1);

  // Epoch tag stored per row; a start command bumps the epoch
  localparam int unsigned EPOCH_W = 4;

  // Fixed field widths
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned VID_W   = 8;
  localparam int unsigned LBL_W   = 16;
  localparam int unsigned ROW_W   = 12;
  localparam int unsigned ELEM_W  = 64;
  localparam int unsigned POS_W   = 12;
  localparam int unsigned TOTAL_W = 13;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_EXT   = 2'd0,
    CMD_ROW   = 2'd1,
    CMD_START = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_FROM_VERTEX = 3'd0,
    CFG_KEY_TO_VERTEX   = 3'd1,
    CFG_KEY_FROM_LABEL  = 3'd2,
    CFG_KEY_EDGE_LABEL  = 3'd3,
    CFG_KEY_TO_LABEL    = 3'd4,
    CFG_UNUSED_5        = 3'd5,
    CFG_UNUSED_6        = 3'd6,
    CFG_UNUSED_7        = 3'd7
  } cfg_reg_e;

  // Key compare status for the current extension
  typedef struct packed {
    logic hit;      // all five fields match and key is backward
    logic forward;  // key from < key to
  } key_status_t;

  // Mark memory access issued on an accepted transaction
  typedef struct packed {
    logic              wr;     // set mark of waddr
    logic [ROW_AW-1:0] waddr;
    logic              rd;     // read mark of the current row position
    logic              final_row;
    logic              start;  // new filter
  } mark_req_t;

  // Mark lookup result for the row held in the middle stage
  typedef struct packed {
    logic marked;
    logic busy;     // clearing sweep in progress
  } mark_status_t;

endpackage

>>> src/backward_edge_row_filter.sv
// Backward-edge row filter: marks rows of an embedding column whose extension edge matches the
// configured backward key, then streams the column and emits each marked row with its compacted
// position; the final row always yields a transaction carrying the total kept, and a forward key
// (from vertex below to vertex) marks nothing and flags forward_key_error_o. One input transaction
// is taken per cycle while in_stall_o is low; the mark table read and the row capture occur when
// a row is accepted into the middle stage, and the result register is loaded from that stage when
// the output is free. Marks live in a MAX_ROWS-deep table of epoch tags, so a start command clears
// all marks by bumping the epoch; after reset, and on every fifteenth start command when the 4-bit
// epoch wraps, a clearing sweep over all MAX_ROWS rows runs with in_stall_o held high.
// Configuration must be written only while the block is idle; the block does not enforce this.
module backward_edge_row_filter (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration
  input  logic                            cfg_we_i,
  input  logic [berf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [berf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // input channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [berf_pkg::CMD_W-1:0]      command_i,
  input  logic [berf_pkg::VID_W-1:0]      ext_from_i,
  input  logic [berf_pkg::VID_W-1:0]      ext_to_i,
  input  logic [berf_pkg::LBL_W-1:0]      ext_from_label_i,
  input  logic [berf_pkg::LBL_W-1:0]      ext_edge_label_i,
  input  logic [berf_pkg::LBL_W-1:0]      ext_to_label_i,
  input  logic [berf_pkg::ROW_W-1:0]      ext_row_i,
  input  logic [berf_pkg::ELEM_W-1:0]     row_element_i,
  input  logic                            final_row_i,
  // result channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            kept_o,
  output logic [berf_pkg::POS_W-1:0]      position_o,
  output logic [berf_pkg::ELEM_W-1:0]     out_element_o,
  output logic                            is_final_o,
  output logic [berf_pkg::TOTAL_W-1:0]    total_kept_o,
  output logic                            forward_key_error_o
);

  berf_pkg::key_status_t  key_status;
  berf_pkg::mark_req_t    mark_req;
  berf_pkg::mark_status_t mark_status;
  berf_pkg::cmd_e         cmd;
  logic                   stage_free;
  logic                   accept;
  logic [31:0]            ext_row_wide;
  logic                   ext_row_ok;

  assign cmd = berf_pkg::cmd_e'(command_i);

  // a transaction is taken when the mark table is not sweeping and the middle stage can move
  assign in_stall_o = mark_status.busy || !stage_free;
  assign accept     = in_valid_i && !in_stall_o;

  // ext rows past the table size are dropped
  assign ext_row_wide = 32'(ext_row_i);
  assign ext_row_ok   = ext_row_wide < 32'(berf_pkg::MAX_ROWS);

  berf_key_regs u_key_regs (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .ext_from_i       (ext_from_i),
    .ext_to_i         (ext_to_i),
    .ext_from_label_i (ext_from_label_i),
    .ext_edge_label_i (ext_edge_label_i),
    .ext_to_label_i   (ext_to_label_i),
    .status_o         (key_status)
  );

  // mark write for matching extensions, mark read for rows, epoch bump for start
  assign mark_req.wr        = accept && (cmd == berf_pkg::CMD_EXT) && key_status.hit && ext_row_ok;
  assign mark_req.waddr     = ext_row_wide[berf_pkg::ROW_AW-1:0];
  assign mark_req.rd        = accept && (cmd == berf_pkg::CMD_ROW);
  assign mark_req.final_row = final_row_i;
  assign mark_req.start     = accept && (cmd == berf_pkg::CMD_START);

  berf_mark_mem u_mark_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (mark_req),
    .status_o (mark_status)
  );

  // rows and start commands move on to the compaction stage; start resets the kept count there
  berf_compact u_compact (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .load_i              (mark_req.rd || mark_req.start),
    .cmd_i               (cmd),
    .element_i           (row_element_i),
    .final_i             (final_row_i),
    .marked_i            (mark_status.marked),
    .forward_i           (key_status.forward),
    .free_o              (stage_free),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .kept_o              (kept_o),
    .position_o          (position_o),
    .out_element_o       (out_element_o),
    .is_final_o          (is_final_o),
    .total_kept_o        (total_kept_o),
    .forward_key_error_o (forward_key_error_o)
  );

endmodule

>>> src/berf_key_regs.sv
module berf_key_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [berf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [berf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic [berf_pkg::VID_W-1:0]      ext_from_i,
  input  logic [berf_pkg::VID_W-1:0]      ext_to_i,
  input  logic [berf_pkg::LBL_W-1:0]      ext_from_label_i,
  input  logic [berf_pkg::LBL_W-1:0]      ext_edge_label_i,
  input  logic [berf_pkg::LBL_W-1:0]      ext_to_label_i,
  output berf_pkg::key_status_t           status_o
);

  logic [berf_pkg::VID_W-1:0] from_vertex_q, to_vertex_q;
  logic [berf_pkg::LBL_W-1:0] from_label_q, edge_label_q, to_label_q;
  logic                       forward;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      from_vertex_q <= '0;
      to_vertex_q   <= '0;
      from_label_q  <= '0;
      edge_label_q  <= '0;
      to_label_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (berf_pkg::cfg_reg_e'(cfg_index_i))
        berf_pkg::CFG_KEY_FROM_VERTEX: from_vertex_q <= cfg_data_i[berf_pkg::VID_W-1:0];
        berf_pkg::CFG_KEY_TO_VERTEX:   to_vertex_q   <= cfg_data_i[berf_pkg::VID_W-1:0];
        berf_pkg::CFG_KEY_FROM_LABEL:  from_label_q  <= cfg_data_i[berf_pkg::LBL_W-1:0];
        berf_pkg::CFG_KEY_EDGE_LABEL:  edge_label_q  <= cfg_data_i[berf_pkg::LBL_W-1:0];
        berf_pkg::CFG_KEY_TO_LABEL:    to_label_q    <= cfg_data_i[berf_pkg::LBL_W-1:0];
        default: ;
      endcase
    end
  end

  assign forward = from_vertex_q < to_vertex_q;

  assign status_o.forward = forward;
  assign status_o.hit     = !forward &&
                            (ext_from_i == from_vertex_q) &&
                            (ext_to_i == to_vertex_q) &&
                            (ext_from_label_i == from_label_q) &&
                            (ext_edge_label_i == edge_label_q) &&
                            (ext_to_label_i == to_label_q);

endmodule

>>> src/berf_mark_mem.sv
module berf_mark_mem (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  berf_pkg::mark_req_t     req_i,
  output berf_pkg::mark_status_t  status_o
);

  localparam logic [berf_pkg::EPOCH_W-1:0] EpochMax   = '1;
  localparam logic [berf_pkg::EPOCH_W-1:0] EpochFirst = berf_pkg::EPOCH_W'(1);
  localparam logic [berf_pkg::ROW_AW-1:0]  LastAddr   = berf_pkg::ROW_AW'(berf_pkg::MAX_ROWS - 1);
  localparam logic [berf_pkg::CNT_W-1:0]   RowLimit   = berf_pkg::CNT_W'(berf_pkg::MAX_ROWS);

  logic [berf_pkg::EPOCH_W-1:0] mem [berf_pkg::MAX_ROWS];

  logic [berf_pkg::EPOCH_W-1:0] epoch_q, epoch_d;
  logic                         busy_q, busy_d;
  logic [berf_pkg::ROW_AW-1:0]  clr_addr_q, clr_addr_d;
  logic [berf_pkg::CNT_W-1:0]   row_pos_q, row_pos_d;
  logic                         row_in_range;
  logic [berf_pkg::EPOCH_W-1:0] rd_data_q;
  logic [berf_pkg::EPOCH_W-1:0] rd_tag_q;
  logic                         rd_valid_q;

  assign row_in_range = row_pos_q < RowLimit;

  // Epoch, sweep and row counter
  always_comb begin
    epoch_d    = epoch_q;
    busy_d     = busy_q;
    clr_addr_d = clr_addr_q;
    row_pos_d  = row_pos_q;
    if (busy_q) begin
      clr_addr_d = clr_addr_q + berf_pkg::ROW_AW'(1);
      if (clr_addr_q == LastAddr) begin
        busy_d     = 1'b0;
        clr_addr_d = '0;
      end
    end
    if (req_i.start) begin
      row_pos_d = '0;
      if (epoch_q == EpochMax) begin
        // tags are about to alias: wipe the table and restart the epoch
        epoch_d = EpochFirst;
        busy_d  = 1'b1;
      end else begin
        epoch_d = epoch_q + berf_pkg::EPOCH_W'(1);
      end
    end else if (req_i.rd) begin
      if (req_i.final_row) begin
        row_pos_d = '0;
      end else if (row_in_range) begin
        row_pos_d = row_pos_q + berf_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      epoch_q    <= EpochFirst;
      busy_q     <= 1'b1;
      clr_addr_q <= '0;
      row_pos_q  <= '0;
    end else begin
      epoch_q    <= epoch_d;
      busy_q     <= busy_d;
      clr_addr_q <= clr_addr_d;
      row_pos_q  <= row_pos_d;
    end
  end

  // Tag table; a tag equal to the live epoch means marked
  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem[clr_addr_q] <= '0;
    end else if (req_i.wr) begin
      mem[req_i.waddr] <= epoch_q;
    end
    if (req_i.rd) begin
      rd_data_q <= mem[row_pos_q[berf_pkg::ROW_AW-1:0]];
      rd_tag_q  <= epoch_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
    end else if (req_i.rd) begin
      rd_valid_q <= row_in_range;
    end
  end

  assign status_o.marked = rd_valid_q && (rd_data_q == rd_tag_q);
  assign status_o.busy   = busy_q;

endmodule

>>> src/berf_compact.sv
module berf_compact (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          load_i,
  input  berf_pkg::cmd_e                cmd_i,
  input  logic [berf_pkg::ELEM_W-1:0]   element_i,
  input  logic                          final_i,
  input  logic                          marked_i,
  input  logic                          forward_i,
  output logic                          free_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          kept_o,
  output logic [berf_pkg::POS_W-1:0]    position_o,
  output logic [berf_pkg::ELEM_W-1:0]   out_element_o,
  output logic                          is_final_o,
  output logic [berf_pkg::TOTAL_W-1:0]  total_kept_o,
  output logic                          forward_key_error_o
);

  localparam logic [berf_pkg::CNT_W-1:0] CntLimit = berf_pkg::CNT_W'(berf_pkg::MAX_ROWS);

  logic                        s1_valid_q;
  berf_pkg::cmd_e              s1_cmd_q;
  logic [berf_pkg::ELEM_W-1:0] s1_elem_q;
  logic                        s1_final_q;
  logic [berf_pkg::CNT_W-1:0]  kept_q, kept_d, kept_inc;
  logic                        out_valid_q, out_valid_d;
  logic                        is_row, marked, produce, out_free, s1_go;

  assign is_row   = s1_cmd_q == berf_pkg::CMD_ROW;
  assign marked   = is_row && marked_i && !forward_i;
  assign produce  = is_row && (marked || s1_final_q);
  assign out_free = !out_valid_q || !out_stall_i;
  assign s1_go    = s1_valid_q && (!produce || out_free);
  assign free_o   = !s1_valid_q || s1_go;

  assign kept_inc = (marked && kept_q < CntLimit) ? kept_q + berf_pkg::CNT_W'(1) : kept_q;

  always_comb begin
    kept_d = kept_q;
    if (s1_go) begin
      if (!is_row || s1_final_q) begin
        kept_d = '0;
      end else begin
        kept_d = kept_inc;
      end
    end
    out_valid_d = out_valid_q && out_stall_i;
    if (s1_go && produce) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      kept_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load_i) begin
        s1_valid_q <= 1'b1;
      end else if (s1_go) begin
        s1_valid_q <= 1'b0;
      end
      kept_q      <= kept_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      s1_cmd_q   <= cmd_i;
      s1_elem_q  <= element_i;
      s1_final_q <= final_i;
    end
    if (s1_go && produce) begin
      kept_o              <= marked;
      position_o          <= marked ? berf_pkg::POS_W'(kept_q) : '0;
      out_element_o       <= marked ? s1_elem_q : '0;
      is_final_o          <= s1_final_q;
      total_kept_o        <= berf_pkg::TOTAL_W'(kept_inc);
      forward_key_error_o <= forward_i;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
